// ----- rtl/core/bffa_pkg.sv -----
// shared types and constants for the bitmap first-fit allocator
package bffa_pkg;

    localparam int MAX_SLOTS_DEF = 1024;
    localparam int MAP_WORD_BITS_DEF = 64;
    localparam int CNT_W = 11;
    localparam int SLOT_W = 10;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_NOFIT = 2'd2;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_WRITE,
        S_CLEAR,
        S_REPORT
    } t_state;

    typedef struct packed {
        logic load;
        logic check;
        logic scan;
        logic write;
        logic clear;
        logic report;
    } t_cmd;

    typedef struct packed {
        logic invalid;
        logic is_release;
        logic scan_hit;
        logic scan_end;
        logic write_end;
        logic clear_end;
    } t_stat;

endpackage

// ----- rtl/core/bffa_ctrl.sv -----
// controller state machine for the allocator
module bffa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_cfg_wr,
    input  bffa_pkg::t_stat  i_stat,
    output logic             o_busy,
    output bffa_pkg::t_cmd   o_cmd
);

    bffa_pkg::t_state r_state;
    bffa_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bffa_pkg::S_CLEAR;
        end else if (i_cfg_wr) begin
            r_state <= bffa_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bffa_pkg::S_IDLE: begin
                if (i_start) n_state = bffa_pkg::S_CHECK;
            end
            bffa_pkg::S_CHECK: begin
                if (i_stat.invalid) n_state = bffa_pkg::S_REPORT;
                else if (i_stat.is_release) n_state = bffa_pkg::S_WRITE;
                else n_state = bffa_pkg::S_SCAN;
            end
            bffa_pkg::S_SCAN: begin
                if (i_stat.scan_hit) n_state = bffa_pkg::S_WRITE;
                else if (i_stat.scan_end) n_state = bffa_pkg::S_REPORT;
            end
            bffa_pkg::S_WRITE: begin
                if (i_stat.write_end) n_state = bffa_pkg::S_REPORT;
            end
            bffa_pkg::S_CLEAR: begin
                if (i_stat.clear_end) n_state = bffa_pkg::S_IDLE;
            end
            bffa_pkg::S_REPORT: n_state = bffa_pkg::S_IDLE;
            default: n_state = bffa_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_busy = 1'b1;
        unique case (r_state)
            bffa_pkg::S_IDLE: begin
                o_busy = 1'b0;
                o_cmd.load = i_start;
            end
            bffa_pkg::S_CHECK: o_cmd.check = 1'b1;
            bffa_pkg::S_SCAN: o_cmd.scan = 1'b1;
            bffa_pkg::S_WRITE: o_cmd.write = 1'b1;
            bffa_pkg::S_CLEAR: o_cmd.clear = 1'b1;
            bffa_pkg::S_REPORT: o_cmd.report = 1'b1;
            default: o_busy = 1'b1;
        endcase
    end

    a_report_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.report && !i_cfg_wr |=> !o_busy) else $error("report not followed by idle");
    a_one_cmd: assert property (@(posedge i_clk) $onehot0(o_cmd))
        else $error("more than one command");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> !o_busy) else $error("load while busy");

endmodule

// ----- rtl/core/bffa_dp.sv -----
// datapath: occupancy memory, run scan, mark and clear sweeps
module bffa_dp #(
    parameter int MAX_SLOTS = bffa_pkg::MAX_SLOTS_DEF,
    parameter int MAP_WORD_BITS = bffa_pkg::MAP_WORD_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bffa_pkg::t_cmd             i_cmd,
    input  logic                       i_cfg_wr,
    input  logic [bffa_pkg::CNT_W-1:0] i_cfg_total,
    input  logic                       i_kind,
    input  logic [bffa_pkg::SLOT_W-1:0] i_first_slot,
    input  logic [bffa_pkg::CNT_W-1:0] i_slot_count,
    output bffa_pkg::t_stat            o_stat,
    output logic [bffa_pkg::CNT_W-1:0] o_total,
    output logic                       o_valid,
    output logic [1:0]                 o_status,
    output logic [bffa_pkg::SLOT_W-1:0] o_run_start,
    output logic [bffa_pkg::CNT_W-1:0] o_free_slots
);

    localparam int WORDS = (MAX_SLOTS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BW = $clog2(MAP_WORD_BITS);
    localparam int IW = AW + BW;
    localparam int BIG_W = (IW + 1 > bffa_pkg::CNT_W) ? IW + 1 : bffa_pkg::CNT_W;
    localparam logic [BIG_W-1:0] MAXV = BIG_W'(MAX_SLOTS);

    logic [MAP_WORD_BITS-1:0] r_mem [WORDS];
    logic [bffa_pkg::CNT_W-1:0] r_total;
    logic r_kind;
    logic [bffa_pkg::SLOT_W-1:0] r_first;
    logic [bffa_pkg::CNT_W-1:0] r_count;
    logic [BIG_W-1:0] r_used;
    logic [BIG_W-1:0] r_pos;
    logic [BIG_W-1:0] r_run;
    logic [BIG_W-1:0] r_rstart;
    logic [BIG_W-1:0] r_end;
    logic [MAP_WORD_BITS-1:0] r_rd;
    logic r_rd_ok;
    logic r_wr_set;
    logic [1:0] r_status;
    logic [AW-1:0] r_clr;

    logic [BIG_W-1:0] tot;
    logic [BIG_W-1:0] cnt_x;
    logic [BIG_W-1:0] first_x;
    logic bad;
    logic bit_used;
    logic [BIG_W-1:0] run_inc;
    logic [BIG_W-1:0] n_pos;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] pos_word;
    logic [BW-1:0] pos_bit;
    logic [BIG_W-1:0] free_w;

    assign tot = (BIG_W'(r_total) > MAXV) ? MAXV : BIG_W'(r_total);
    assign cnt_x = BIG_W'(r_count);
    assign first_x = BIG_W'(r_first);
    assign o_total = r_total;
    assign pos_word = r_pos[BW +: AW];
    assign pos_bit = r_pos[BW-1:0];
    assign bit_used = r_rd[pos_bit];
    assign run_inc = r_run + 1'b1;
    assign n_pos = r_pos + 1'b1;

    always_comb begin
        if (r_kind == bffa_pkg::KIND_ALLOC) begin
            bad = (r_count == '0) || (cnt_x > tot);
        end else begin
            bad = (r_count == '0) || (first_x >= tot)
                  || ({1'b0, first_x} + {1'b0, cnt_x} > {1'b0, tot});
        end
    end

    // read address follows the next position once the current word is exhausted
    always_comb begin
        rd_addr = pos_word;
        if (r_rd_ok && (pos_bit == BW'(MAP_WORD_BITS - 1))) begin
            rd_addr = n_pos[BW +: AW];
        end
    end

    assign o_stat.invalid = bad;
    assign o_stat.is_release = (r_kind == bffa_pkg::KIND_RELEASE);
    assign o_stat.scan_hit = r_rd_ok && (r_pos < tot) && !bit_used && (run_inc == cnt_x);
    assign o_stat.scan_end = r_rd_ok && (n_pos >= tot);
    assign o_stat.write_end = r_rd_ok && (n_pos >= r_end);
    assign o_stat.clear_end = (r_clr == AW'(WORDS - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_mem[r_clr] <= '0;
        end else if (i_cmd.write && r_rd_ok) begin
            r_mem[pos_word] <= r_wr_set ? (r_rd | (MAP_WORD_BITS'(1) << pos_bit))
                                        : (r_rd & ~(MAP_WORD_BITS'(1) << pos_bit));
        end
        if (!r_rd_ok || pos_bit == BW'(MAP_WORD_BITS - 1)) begin
            r_rd <= r_mem[rd_addr];
        end else if (i_cmd.write) begin
            r_rd[pos_bit] <= r_wr_set;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_used <= '0;
            r_clr <= '0;
            o_valid <= 1'b0;
            r_rd_ok <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (i_cfg_wr) begin
                r_total <= i_cfg_total;
                r_used <= '0;
                r_clr <= '0;
            end else if (i_cmd.clear) begin
                r_clr <= r_clr + 1'b1;
                r_used <= '0;
            end
            if (i_cmd.load) begin
                r_rd_ok <= 1'b0;
            end else if (i_cmd.check) begin
                r_rd_ok <= 1'b0;
            end else if (i_cmd.scan && r_rd_ok && o_stat.scan_hit) begin
                r_rd_ok <= 1'b0;
            end else if (i_cmd.scan || i_cmd.write) begin
                r_rd_ok <= 1'b1;
            end
            if (i_cmd.write && r_rd_ok) begin
                if (r_wr_set && !bit_used) r_used <= r_used + 1'b1;
                else if (!r_wr_set && bit_used) r_used <= r_used - 1'b1;
            end
            if (i_cmd.report) o_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_first <= i_first_slot;
            r_count <= i_slot_count;
        end
        if (i_cmd.check) begin
            r_run <= '0;
            r_rstart <= '0;
            r_status <= bad ? bffa_pkg::ST_INVALID : bffa_pkg::ST_DONE;
            r_wr_set <= (r_kind == bffa_pkg::KIND_ALLOC);
            r_pos <= (r_kind == bffa_pkg::KIND_RELEASE) ? first_x : '0;
            r_end <= first_x + cnt_x;
        end
        if (i_cmd.scan && r_rd_ok) begin
            if (o_stat.scan_hit) begin
                r_pos <= r_rstart;
                r_end <= r_rstart + cnt_x;
            end else begin
                if (o_stat.scan_end) r_status <= bffa_pkg::ST_NOFIT;
                if (bit_used) begin
                    r_run <= '0;
                    r_rstart <= n_pos;
                end else begin
                    r_run <= run_inc;
                end
                r_pos <= n_pos;
            end
        end
        if (i_cmd.write && r_rd_ok) begin
            r_pos <= n_pos;
        end
    end

    assign free_w = tot - ((r_used > tot) ? tot : r_used);

    always_ff @(posedge i_clk) begin
        if (i_cmd.report) begin
            o_status <= r_status;
            o_run_start <= (r_status == bffa_pkg::ST_DONE && r_kind == bffa_pkg::KIND_ALLOC)
                           ? r_rstart[bffa_pkg::SLOT_W-1:0] : '0;
            o_free_slots <= free_w[bffa_pkg::CNT_W-1:0];
        end
    end

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= MAXV) else $error("used count out of range");
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe longer than one cycle");
    a_clear_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> r_used == '0) else $error("used count not cleared");

endmodule

// ----- rtl/core/bitmap_first_fit_range_allocator_top.sv -----
// top level of the bitmap first-fit range allocator
// usage:
//   requests enter on start when busy is low; fields i_kind, i_first_slot,
//   i_slot_count are captured that cycle
//   a result word appears for one cycle with o_done high: o_status,
//   o_run_start, o_free_slots; the receiver cannot stall it
//   total_slots is written over the apb port at address 0 and clears the
//   map; the user must write it only while idle, the block does not enforce it
// operation:
//   an invalid request goes from the check to the report; allocate scans one
//   slot per cycle from slot 0 up to the hit or the total, then marks the
//   run one slot per cycle; release clears its range one slot per cycle;
//   one request at a time, the next one can enter in the cycle of the word
// reset:
//   a clearing pass sweeps the map word by word while busy stays high;
//   the same pass follows every total_slots write
module bitmap_first_fit_range_allocator_top #(
    parameter int MAX_SLOTS = bffa_pkg::MAX_SLOTS_DEF,
    parameter int MAP_WORD_BITS = bffa_pkg::MAP_WORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_kind,
    input  logic [bffa_pkg::SLOT_W-1:0] i_first_slot,
    input  logic [bffa_pkg::CNT_W-1:0]  i_slot_count,
    output logic                        o_done,
    output logic [1:0]                  o_status,
    output logic [bffa_pkg::SLOT_W-1:0] o_run_start,
    output logic [bffa_pkg::CNT_W-1:0]  o_free_slots,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [1:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    bffa_pkg::t_cmd cmd;
    bffa_pkg::t_stat stat;
    logic cfg_wr;
    logic [bffa_pkg::CNT_W-1:0] total;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == 2'd0);
    assign prdata = (paddr == 2'd0) ? {21'd0, total} : 32'd0;

    bffa_ctrl u_ctrl (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_cfg_wr(cfg_wr),
        .i_stat(stat),
        .o_busy(busy),
        .o_cmd(cmd)
    );

    bffa_dp #(
        .MAX_SLOTS(MAX_SLOTS),
        .MAP_WORD_BITS(MAP_WORD_BITS)
    ) u_dp (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd(cmd),
        .i_cfg_wr(cfg_wr),
        .i_cfg_total(pwdata[bffa_pkg::CNT_W-1:0]),
        .i_kind(i_kind),
        .i_first_slot(i_first_slot),
        .i_slot_count(i_slot_count),
        .o_stat(stat),
        .o_total(total),
        .o_valid(o_done),
        .o_status(o_status),
        .o_run_start(o_run_start),
        .o_free_slots(o_free_slots)
    );

endmodule
